### src/gct_pkg.sv
`timescale 1ns / 1ps
// Package for the geometric collision test unit: widths, command codes,
// transaction types and the difference multiplier. No dependencies.
package gct_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int RAD_W       = COORD_WIDTH - 1;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int CROSS_W     = 2 * COORD_WIDTH + 3;
  localparam int QUOT_W      = COORD_WIDTH + 1;
  localparam int NUM_W       = DIFF_W + CROSS_W;
  localparam int RA2_W       = 2 * RAD_W;

  localparam int ST_DIFF = 0;
  localparam int ST_PROD = 1;
  localparam int ST_HIT  = 2;
  localparam int ST_MULB = 3;
  localparam int ST_ABS  = 4;
  localparam int ST_DIV0 = 5;
  localparam int ST_OUT  = ST_DIV0 + QUOT_W + 1;
  localparam int NSTAGE  = ST_OUT + 1;

  localparam logic [1:0] CMD_CIRCLES    = 2'd0;
  localparam logic [1:0] CMD_CIRCLE_SEG = 2'd1;
  localparam logic [1:0] CMD_SEGMENTS   = 2'd2;

  typedef struct packed {
    logic [1:0]                    command;
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic signed [COORD_WIDTH-1:0] d_x;
    logic signed [COORD_WIDTH-1:0] d_y;
    logic [RAD_W-1:0]              radius_a;
    logic [RAD_W-1:0]              radius_b;
  } gct_req_t;

  typedef struct packed {
    logic                          hit;
    logic                          point_valid;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
  } gct_rsp_t;

  function automatic logic signed [CROSS_W-1:0] dmul(input logic signed [DIFF_W-1:0] x,
                                                     input logic signed [DIFF_W-1:0] y);
    dmul = CROSS_W'(x) * CROSS_W'(y);
  endfunction

endpackage

### src/geometric_collision_test_unit.sv
`timescale 1ns / 1ps
// Geometric collision test unit top level: circle and segment tests.
// Depends on gct_pkg, gct_mul and gct_div.
//
// Each request transaction gives exactly one response transaction, in order.
// The unit accepts one request per cycle unless a stalled response has filled the
// pipeline; the divider forms the projection or intersection point one quotient
// bit per stage.
// Every stage moves on its own when the next one is free, so empty slots
// close up and requests keep flowing while a finished response waits.
module geometric_collision_test_unit
  import gct_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  gct_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output gct_rsp_t rsp
);

  localparam int W     = COORD_WIDTH;
  localparam int SUM_W = W + 3;
  localparam logic signed [W-1:0] PT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] PT_MIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic                hit;
    logic                pv;
    logic                negx;
    logic                negy;
    logic signed [W-1:0] base_x;
    logic signed [W-1:0] base_y;
  } side_t;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || rsp_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign req_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= req_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // differences
  logic [1:0]               s0_cmd;
  logic signed [DIFF_W-1:0] cax, cay, rx, ry, qx, qy, dax, day, bcx, bcy;
  logic signed [W-1:0]      s0_bx, s0_by;
  logic [RAD_W-1:0]         s0_ra;
  logic [W-1:0]             s0_ssum;

  always_ff @(posedge clk) begin
    if (en[ST_DIFF]) begin
      s0_cmd  <= req.command;
      cax     <= DIFF_W'(req.c_x) - DIFF_W'(req.a_x);
      cay     <= DIFF_W'(req.c_y) - DIFF_W'(req.a_y);
      rx      <= DIFF_W'(req.b_x) - DIFF_W'(req.a_x);
      ry      <= DIFF_W'(req.b_y) - DIFF_W'(req.a_y);
      qx      <= DIFF_W'(req.d_x) - DIFF_W'(req.c_x);
      qy      <= DIFF_W'(req.d_y) - DIFF_W'(req.c_y);
      dax     <= DIFF_W'(req.d_x) - DIFF_W'(req.a_x);
      day     <= DIFF_W'(req.d_y) - DIFF_W'(req.a_y);
      bcx     <= DIFF_W'(req.b_x) - DIFF_W'(req.c_x);
      bcy     <= DIFF_W'(req.b_y) - DIFF_W'(req.c_y);
      s0_bx   <= (req.command == CMD_CIRCLE_SEG) ? req.c_x : req.a_x;
      s0_by   <= (req.command == CMD_CIRCLE_SEG) ? req.c_y : req.a_y;
      s0_ra   <= req.radius_a;
      s0_ssum <= W'(req.radius_a) + W'(req.radius_b);
    end
  end

  // products and cross products
  logic [1:0]                s1_cmd;
  logic signed [DIFF_W-1:0]  s1_mx, s1_my;
  logic signed [CROSS_W-1:0] s1_k, s1_dn, s1_d2, s1_tn, s1_s1, s1_s2, s1_t2;
  logic [2*W-1:0]            s1_ssq;
  logic signed [W-1:0]       s1_bx, s1_by;
  logic [RAD_W-1:0]          s1_ra;
  logic signed [CROSS_W-1:0] tn_c, dotn_c, vv_c, den_c;
  logic                      is_cs;

  assign tn_c   = dmul(qy, cax) - dmul(qx, cay);
  assign dotn_c = dmul(cax, qx) + dmul(cay, qy);
  assign vv_c   = dmul(qx, qx) + dmul(qy, qy);
  assign den_c  = dmul(rx, qy) - dmul(ry, qx);
  assign is_cs  = s0_cmd == CMD_CIRCLE_SEG;

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      s1_cmd <= s0_cmd;
      s1_mx  <= is_cs ? qx : rx;
      s1_my  <= is_cs ? qy : ry;
      s1_k   <= is_cs ? -dotn_c : tn_c;
      s1_dn  <= is_cs ? vv_c : den_c;
      s1_d2  <= dmul(cax, cax) + dmul(cay, cay);
      s1_ssq <= (2*W)'(s0_ssum) * (2*W)'(s0_ssum);
      s1_tn  <= tn_c;
      s1_s1  <= dmul(rx, day) - dmul(ry, dax);
      s1_s2  <= dmul(rx, cay) - dmul(ry, cax);
      s1_t2  <= dmul(qx, bcy) - dmul(qy, bcx);
      s1_bx  <= s0_bx;
      s1_by  <= s0_by;
      s1_ra  <= s0_ra;
    end
  end

  // hit tests that need no further product (circle-segment: range part only)
  logic                      s2_hit, s2_chk, s2_pv;
  logic signed [CROSS_W-1:0] s2_dn;
  logic [CROSS_W-1:0]        s2_mag;
  logic [RA2_W-1:0]          s2_ra2;
  logic signed [W-1:0]       s2_bx, s2_by;
  logic                      pv_c, same_c, opp_c, hit_c;

  function automatic logic sg_pos(input logic signed [CROSS_W-1:0] v);
    sg_pos = !v[CROSS_W-1] && (v != '0);
  endfunction

  always_comb begin
    pv_c   = ((s1_cmd == CMD_CIRCLE_SEG) || (s1_cmd == CMD_SEGMENTS)) && (s1_dn != '0);
    same_c = (sg_pos(s1_s1) && sg_pos(s1_s2)) || (s1_s1[CROSS_W-1] && s1_s2[CROSS_W-1]);
    opp_c  = (sg_pos(s1_tn) && s1_t2[CROSS_W-1]) || (s1_tn[CROSS_W-1] && sg_pos(s1_t2));
    unique case (s1_cmd)
      CMD_CIRCLES:    hit_c = $unsigned(s1_d2) < CROSS_W'(s1_ssq);
      CMD_CIRCLE_SEG: hit_c = pv_c && !s1_k[CROSS_W-1] && (s1_k <= s1_dn);
      CMD_SEGMENTS:   hit_c = !same_c && opp_c;
      default:        hit_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ST_HIT]) begin
      s2_hit <= hit_c;
      s2_chk <= s1_cmd == CMD_CIRCLE_SEG;
      s2_pv  <= pv_c;
      s2_dn  <= s1_dn;
      s2_mag <= s1_tn[CROSS_W-1] ? CROSS_W'(-s1_tn) : CROSS_W'(s1_tn);
      s2_ra2 <= RA2_W'(s1_ra) * RA2_W'(s1_ra);
      s2_bx  <= s1_bx;
      s2_by  <= s1_by;
    end
  end

  logic signed [NUM_W-1:0] nx, ny;

  gct_mul #(.A_W(DIFF_W), .B_W(CROSS_W)) u_mul_x (
    .clk(clk), .en_a(en[ST_HIT]), .en_b(en[ST_MULB]), .a(s1_mx), .b(s1_k), .p(nx)
  );

  gct_mul #(.A_W(DIFF_W), .B_W(CROSS_W)) u_mul_y (
    .clk(clk), .en_a(en[ST_HIT]), .en_b(en[ST_MULB]), .a(s1_my), .b(s1_k), .p(ny)
  );

  logic signed [2*CROSS_W+1:0]       c2;
  logic signed [RA2_W+CROSS_W:0]     rv;

  gct_mul #(.A_W(CROSS_W+1), .B_W(CROSS_W+1)) u_mul_c2 (
    .clk(clk), .en_a(en[ST_MULB]), .en_b(en[ST_ABS]),
    .a($signed({1'b0, s2_mag})), .b($signed({1'b0, s2_mag})), .p(c2)
  );

  gct_mul #(.A_W(RA2_W+1), .B_W(CROSS_W)) u_mul_rv (
    .clk(clk), .en_a(en[ST_MULB]), .en_b(en[ST_ABS]),
    .a($signed({1'b0, s2_ra2})), .b(s2_dn), .p(rv)
  );

  logic                      s3_hit, s3_chk, s3_pv;
  logic signed [CROSS_W-1:0] s3_dn;
  logic signed [W-1:0]       s3_bx, s3_by;

  always_ff @(posedge clk) begin
    if (en[ST_MULB]) begin
      s3_hit <= s2_hit;
      s3_chk <= s2_chk;
      s3_pv  <= s2_pv;
      s3_dn  <= s2_dn;
      s3_bx  <= s2_bx;
      s3_by  <= s2_by;
    end
  end

  // magnitudes and quotient signs
  logic                s4_hit, s4_chk, s4_pv, s4_negx, s4_negy;
  logic [NUM_W-1:0]    s4_nx, s4_ny;
  logic [CROSS_W-1:0]  s4_d;
  logic signed [W-1:0] s4_bx, s4_by;

  always_ff @(posedge clk) begin
    if (en[ST_ABS]) begin
      s4_hit  <= s3_hit;
      s4_chk  <= s3_chk;
      s4_pv   <= s3_pv;
      s4_negx <= nx[NUM_W-1] ^ s3_dn[CROSS_W-1];
      s4_negy <= ny[NUM_W-1] ^ s3_dn[CROSS_W-1];
      s4_nx   <= nx[NUM_W-1] ? NUM_W'(-nx) : NUM_W'(nx);
      s4_ny   <= ny[NUM_W-1] ? NUM_W'(-ny) : NUM_W'(ny);
      s4_d    <= s3_dn[CROSS_W-1] ? CROSS_W'(-s3_dn) : CROSS_W'(s3_dn);
      s4_bx   <= s3_bx;
      s4_by   <= s3_by;
    end
  end

  logic [QUOT_W-1:0] qu_x, qu_y;
  logic              ov_x, ov_y;

  gct_div #(.N_W(NUM_W), .D_W(CROSS_W), .Q_W(QUOT_W)) u_div (
    .clk(clk), .en(en[ST_DIV0 +: QUOT_W+1]),
    .num_x(s4_nx), .num_y(s4_ny), .den(s4_d),
    .quo_x(qu_x), .quo_y(qu_y), .ovf_x(ov_x), .ovf_y(ov_y)
  );

  side_t side [QUOT_W+1];

  always_ff @(posedge clk) begin
    if (en[ST_DIV0]) begin
      side[0].hit    <= s4_hit && (!s4_chk || (c2 < (2*CROSS_W+2)'(rv)));
      side[0].pv     <= s4_pv;
      side[0].negx   <= s4_negx;
      side[0].negy   <= s4_negy;
      side[0].base_x <= s4_bx;
      side[0].base_y <= s4_by;
    end
  end

  for (genvar i = 1; i <= QUOT_W; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[ST_DIV0+i]) begin
        side[i] <= side[i-1];
      end
    end
  end

  function automatic logic signed [W-1:0] place(input logic signed [W-1:0] base,
                                                input logic [QUOT_W-1:0]   q,
                                                input logic                neg,
                                                input logic                ovf);
    logic signed [QUOT_W:0] qs;
    logic signed [SUM_W-1:0] sum;
    qs  = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    sum = SUM_W'(base) + SUM_W'(qs);
    if (ovf) begin
      place = neg ? PT_MIN : PT_MAX;
    end else if (sum > SUM_W'(PT_MAX)) begin
      place = PT_MAX;
    end else if (sum < SUM_W'(PT_MIN)) begin
      place = PT_MIN;
    end else begin
      place = sum[W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      rsp.hit         <= side[QUOT_W].hit;
      rsp.point_valid <= side[QUOT_W].pv;
      rsp.point_x     <= side[QUOT_W].pv ?
                         place(side[QUOT_W].base_x, qu_x, side[QUOT_W].negx, ov_x) : '0;
      rsp.point_y     <= side[QUOT_W].pv ?
                         place(side[QUOT_W].base_y, qu_y, side[QUOT_W].negy, ov_y) : '0;
    end
  end

  assign rsp_valid = vld[ST_OUT];

`ifndef SYNTH
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (vld[ST_OUT] && !rsp_ready))
    else $error("request side stalled with room in the pipeline");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> vld[ST_DIFF])
    else $error("accepted transaction did not enter the first stage");

  a_no_point_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.point_valid) |-> (rsp.point_x == '0 && rsp.point_y == '0))
    else $error("point fields nonzero without a point");

  a_refill: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready && vld[ST_OUT-1]) |=> rsp_valid)
    else $error("queued transaction lost at the output stage");
`endif

endmodule

### src/gct_mul.sv
`timescale 1ns / 1ps
// Two-stage signed multiplier: split partial products, then sum.
// Standalone; stage enables come from the owning pipeline.
module gct_mul #(
  parameter int A_W = 17,
  parameter int B_W = 35
) (
  input  logic                        clk,
  input  logic                        en_a,
  input  logic                        en_b,
  input  logic signed [A_W-1:0]       a,
  input  logic signed [B_W-1:0]       b,
  output logic signed [A_W+B_W-1:0]   p
);

  localparam int LO_W = B_W / 2;
  localparam int HI_W = B_W - LO_W;
  localparam int P_W  = A_W + B_W;

  logic signed [A_W+LO_W:0]   pl;
  logic signed [A_W+HI_W-1:0] ph;
  logic signed [LO_W:0]       b_lo;
  logic signed [HI_W-1:0]     b_hi;

  assign b_lo = $signed({1'b0, b[LO_W-1:0]});
  assign b_hi = b[B_W-1:LO_W];

  always_ff @(posedge clk) begin
    if (en_a) begin
      pl <= (A_W+LO_W+1)'(a) * (A_W+LO_W+1)'(b_lo);
      ph <= (A_W+HI_W)'(a) * (A_W+HI_W)'(b_hi);
    end
    if (en_b) begin
      p <= (P_W'(ph) <<< LO_W) + P_W'(pl);
    end
  end

endmodule

### src/gct_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, two numerators over one divisor, one quotient
// bit per stage with an overflow flag. Standalone; N_W must be D_W + Q_W.
module gct_div #(
  parameter int N_W = 52,
  parameter int D_W = 35,
  parameter int Q_W = 17
) (
  input  logic           clk,
  input  logic [Q_W:0]   en,
  input  logic [N_W-1:0] num_x,
  input  logic [N_W-1:0] num_y,
  input  logic [D_W-1:0] den,
  output logic [Q_W-1:0] quo_x,
  output logic [Q_W-1:0] quo_y,
  output logic           ovf_x,
  output logic           ovf_y
);

  logic [N_W-1:0] rem_x [Q_W+1];
  logic [N_W-1:0] rem_y [Q_W+1];
  logic [Q_W-1:0] qx    [Q_W+1];
  logic [Q_W-1:0] qy    [Q_W+1];
  logic [D_W-1:0] dd    [Q_W+1];
  logic           ox    [Q_W+1];
  logic           oy    [Q_W+1];
  logic [N_W-1:0] dsh;

  assign dsh = N_W'(den) << Q_W;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_x[0] <= num_x;
      rem_y[0] <= num_y;
      ox[0]    <= num_x >= dsh;
      oy[0]    <= num_y >= dsh;
      qx[0]    <= '0;
      qy[0]    <= '0;
      dd[0]    <= den;
    end
  end

  for (genvar s = 1; s <= Q_W; s++) begin : g_bit
    localparam int J = Q_W - s;
    logic [N_W-1:0] t;
    logic           gx;
    logic           gy;

    assign t  = N_W'(dd[s-1]) << J;
    assign gx = rem_x[s-1] >= t;
    assign gy = rem_y[s-1] >= t;

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_x[s] <= gx ? rem_x[s-1] - t : rem_x[s-1];
        rem_y[s] <= gy ? rem_y[s-1] - t : rem_y[s-1];
        qx[s]    <= qx[s-1] | (Q_W'(gx) << J);
        qy[s]    <= qy[s-1] | (Q_W'(gy) << J);
        ox[s]    <= ox[s-1];
        oy[s]    <= oy[s-1];
        dd[s]    <= dd[s-1];
      end
    end
  end

  assign quo_x = qx[Q_W];
  assign quo_y = qy[Q_W];
  assign ovf_x = ox[Q_W];
  assign ovf_y = oy[Q_W];

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Testbench for geometric_collision_test_unit: directed and random collision
// tests checked against a local exact-arithmetic predictor. Depends on gct_pkg and the DUT.
module testbench;
  import gct_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam logic [1:0] CMD_NONE = 2'd3;

  logic     clk;
  logic     rst;
  logic     req_valid = 1'b0;
  logic     req_ready;
  gct_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  gct_rsp_t rsp;

  gct_req_t pending[$];
  gct_rsp_t expected_rsp[$];
  bit       req_took = 1'b0;
  bit       failed = 1'b0;
  int       req_gap = 0;
  int       rsp_stall = 0;
  longint   cycles = 0;

  geometric_collision_test_unit u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic wide_t cross2(wide_t ux, wide_t uy, wide_t wx, wide_t wy);
    return ux * wy - uy * wx;
  endfunction

  function automatic int sign_of(wide_t v);
    return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] clip(wide_t v);
    wide_t top;
    top = (wide_t'(1) <<< (COORD_WIDTH - 1)) - 1;
    if (v > top) v = top;
    if (v < -top - 1) v = -top - 1;
    return v[COORD_WIDTH-1:0];
  endfunction

  function automatic gct_rsp_t collide(gct_req_t q);
    wide_t ax, ay, bx, by, cx, cy, dx, dy, ra, rb;
    wide_t ex, ey, vx, vy, px, py, vv, dot, cr, den, tn;
    int s1, s2, t1, t2;
    gct_rsp_t r;
    ax = q.a_x; ay = q.a_y; bx = q.b_x; by = q.b_y;
    cx = q.c_x; cy = q.c_y; dx = q.d_x; dy = q.d_y;
    ra = wide_t'({1'b0, q.radius_a});
    rb = wide_t'({1'b0, q.radius_b});
    r = '0;
    if (q.command == CMD_CIRCLES) begin
      ex = cx - ax; ey = cy - ay;
      r.hit = (ex * ex + ey * ey) < (ra + rb) * (ra + rb);
    end else if (q.command == CMD_CIRCLE_SEG) begin
      px = ax - cx; py = ay - cy; vx = dx - cx; vy = dy - cy;
      vv = vx * vx + vy * vy;
      if (vv != 0) begin
        dot = px * vx + py * vy;
        r.point_valid = 1'b1;
        r.point_x = clip(cx + (vx * dot) / vv);
        r.point_y = clip(cy + (vy * dot) / vv);
        cr = cross2(vx, vy, px, py);
        r.hit = dot >= 0 && dot <= vv && cr * cr < ra * ra * vv;
      end
    end else if (q.command == CMD_SEGMENTS) begin
      ex = bx - ax; ey = by - ay; vx = dx - cx; vy = dy - cy;
      s1 = sign_of(cross2(ex, ey, dx - ax, dy - ay));
      s2 = sign_of(cross2(ex, ey, cx - ax, cy - ay));
      t1 = sign_of(cross2(vx, vy, ax - cx, ay - cy));
      t2 = sign_of(cross2(vx, vy, bx - cx, by - cy));
      r.hit = !(s1 * s2 > 0) && (t1 * t2 < 0);
      den = cross2(ex, ey, vx, vy);
      if (den != 0) begin
        tn = cross2(cx - ax, cy - ay, vx, vy);
        r.point_valid = 1'b1;
        r.point_x = clip(ax + (ex * tn) / den);
        r.point_y = clip(ay + (ey * tn) / den);
      end
    end
    return r;
  endfunction

  task automatic add_test(logic [1:0] cmd, int ax, int ay, int bx, int by, int cx, int cy,
                          int dx, int dy, int ra, int rb);
    gct_req_t q;
    q.command = cmd;
    q.a_x = ax[15:0]; q.a_y = ay[15:0]; q.b_x = bx[15:0]; q.b_y = by[15:0];
    q.c_x = cx[15:0]; q.c_y = cy[15:0]; q.d_x = dx[15:0]; q.d_y = dy[15:0];
    q.radius_a = ra[RAD_W-1:0]; q.radius_b = rb[RAD_W-1:0];
    pending.push_back(q);
  endtask

  function automatic int pick_coord(bit near);
    if (near) return $urandom_range(0, 600) - 300;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  task automatic add_random();
    gct_req_t q;
    bit near;
    near = ($urandom_range(0, 9) < 7);
    q = '0;
    q.command = ($urandom_range(0, 30) == 0) ? CMD_NONE : 2'($urandom_range(0, 2));
    q.a_x = COORD_WIDTH'(pick_coord(near)); q.a_y = COORD_WIDTH'(pick_coord(near));
    q.b_x = COORD_WIDTH'(pick_coord(near)); q.b_y = COORD_WIDTH'(pick_coord(near));
    q.c_x = COORD_WIDTH'(pick_coord(near)); q.c_y = COORD_WIDTH'(pick_coord(near));
    q.d_x = COORD_WIDTH'(pick_coord(near)); q.d_y = COORD_WIDTH'(pick_coord(near));
    q.radius_a = near ? RAD_W'($urandom_range(0, 300)) : RAD_W'($urandom);
    q.radius_b = near ? RAD_W'($urandom_range(0, 300)) : RAD_W'($urandom);
    if (q.command == CMD_CIRCLE_SEG && $urandom_range(0, 20) == 0) begin
      q.d_x = q.c_x; q.d_y = q.c_y;
    end
    if (q.command == CMD_SEGMENTS && $urandom_range(0, 15) == 0) begin
      q.d_x = q.c_x + (q.b_x - q.a_x); q.d_y = q.c_y + (q.b_y - q.a_y);
    end
    pending.push_back(q);
  endtask

  function automatic int draw_wait();
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 11);
    return 0;
  endfunction

  initial begin
    add_test(CMD_CIRCLES, 0, 0, 0, 0, 30, 40, 0, 0, 20, 30);
    add_test(CMD_CIRCLES, 0, 0, 0, 0, 30, 40, 0, 0, 20, 31);
    add_test(CMD_CIRCLES, -32768, -32768, 0, 0, 32767, 32767, 0, 0, 32767, 32767);
    add_test(CMD_CIRCLES, 32767, -32768, 0, 0, -32768, 32767, 0, 0, 0, 0);
    add_test(CMD_CIRCLES, 5, 5, 0, 0, 5, 5, 0, 0, 0, 0);
    add_test(CMD_CIRCLE_SEG, 0, 10, 0, 0, 0, 0, 100, 0, 10, 0);
    add_test(CMD_CIRCLE_SEG, 0, 10, 0, 0, 0, 0, 100, 0, 11, 0);
    add_test(CMD_CIRCLE_SEG, 100, 5, 0, 0, 0, 0, 100, 0, 20, 0);
    add_test(CMD_CIRCLE_SEG, -1, 5, 0, 0, 0, 0, 100, 0, 20, 0);
    add_test(CMD_CIRCLE_SEG, 7, 7, 0, 0, 3, 3, 3, 3, 100, 0);
    add_test(CMD_CIRCLE_SEG, 32767, 32767, 0, 0, -32768, -32768, -32767, 32767, 32767, 0);
    add_test(CMD_CIRCLE_SEG, -32768, 32767, 0, 0, 32767, -32768, 32767, -32767, 1, 0);
    add_test(CMD_SEGMENTS, 0, 0, 100, 100, 0, 100, 100, 0, 0, 0);
    add_test(CMD_SEGMENTS, 0, 0, 100, 0, 50, 0, 50, 100, 0, 0);
    add_test(CMD_SEGMENTS, 0, 0, 100, 0, 0, 10, 100, 10, 0, 0);
    add_test(CMD_SEGMENTS, 0, 0, 100, 0, 0, 0, 50, 0, 0, 0);
    add_test(CMD_SEGMENTS, 0, 0, 0, 0, 5, 5, 5, 5, 0, 0);
    add_test(CMD_SEGMENTS, -32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 0, 0);
    add_test(CMD_SEGMENTS, -32768, 0, -32767, 1, 32767, 0, 32767, -32768, 0, 0);
    add_test(CMD_SEGMENTS, 0, 0, 1, 1, 100, 0, 200, 1, 0, 0);
    add_test(CMD_NONE, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10);
    add_test(CMD_NONE, -1, -1, -1, -1, -1, -1, -1, -1, 32767, 32767);
    repeat (1900) add_random();
    @(negedge clk);
    while (rst) @(negedge clk);
    do begin
      @(negedge clk);
      #1;
    end while (pending.size() != 0 || req_valid || expected_rsp.size() != 0);
    repeat (40) @(negedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!req_valid || req_took) begin
        if (req_gap > 0) begin
          req_valid <= 1'b0;
          req_gap = req_gap - 1;
        end else if (pending.size() != 0) begin
          req <= pending.pop_front();
          req_valid <= 1'b1;
          req_gap = draw_wait();
        end else begin
          req_valid <= 1'b0;
        end
      end
      if (rsp_stall > 0) begin
        rsp_ready <= 1'b0;
        rsp_stall = rsp_stall - 1;
      end else begin
        rsp_ready <= 1'b1;
        if (rsp_valid) rsp_stall = draw_wait();
      end
    end
  end

  always @(posedge clk) begin
    gct_rsp_t want;
    cycles = cycles + 1;
    if (cycles > 400000) begin
      $display("Some tests failed");
      $finish;
    end
    req_took = !rst && req_valid && req_ready;
    if (req_took) expected_rsp.push_back(collide(req));
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected transaction hit=%b pv=%b x=%0d y=%0d", $time,
                 rsp.hit, rsp.point_valid, rsp.point_x, rsp.point_y);
        failed = 1'b1;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.hit !== want.hit || rsp.point_valid !== want.point_valid ||
            rsp.point_x !== want.point_x || rsp.point_y !== want.point_y) begin
          $display("%0t: mismatch expected hit=%b pv=%b x=%0d y=%0d, actual hit=%b pv=%b x=%0d y=%0d",
                   $time, want.hit, want.point_valid, want.point_x, want.point_y,
                   rsp.hit, rsp.point_valid, rsp.point_x, rsp.point_y);
          failed = 1'b1;
        end
      end
    end
  end

endmodule

### files.f
src/gct_pkg.sv
src/gct_mul.sv
src/gct_div.sv
src/geometric_collision_test_unit.sv
bench/testbench.sv
